### rtl/tree_slot_allocator_assert.svh
// assertion macros used by the checker file
`ifndef TREE_SLOT_ALLOCATOR_ASSERT_SVH
`define TREE_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define TSA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tsa assertion failed");

// next-cycle implication, sampled on i_clk, off while in reset
`define TSA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tsa assertion failed");

`endif

### rtl/tsa_pkg.sv
`default_nettype none

package tsa_pkg;

    localparam int CMD_W    = 1;
    localparam int IDX_W    = 8;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;
    localparam int FREE_W   = 7;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE      = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_ALREADY_FREE = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACQ,
        S_RLS_CHK,
        S_RLS_UP,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

### rtl/tsa_in_if.sv
`default_nettype none

interface tsa_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [tsa_pkg::IDX_W-1:0]   slot_index;

    modport source (output valid, output cmd, output slot_index, input ready);
    modport sink   (input valid, input cmd, input slot_index, output ready);
endinterface

`default_nettype wire

### rtl/tsa_out_if.sv
`default_nettype none

interface tsa_out_if;
    logic                          valid;
    logic                          ready;
    logic [tsa_pkg::STATUS_W-1:0]  status;
    logic [tsa_pkg::SLOT_W-1:0]    granted_slot;
    logic [tsa_pkg::FREE_W-1:0]    free_count;

    modport source (output valid, output status, output granted_slot, output free_count,
                    input ready);
    modport sink   (input valid, input status, input granted_slot, input free_count,
                    output ready);
endinterface

`default_nettype wire

### rtl/tsa_ram.sv
`default_nettype none

module tsa_ram #(
    parameter int WIDTH = 7,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [(1 << AW)];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/tree_slot_allocator.sv
`default_nettype none
// channel   dir  payload                                   handshake
// i_req     in   cmd, slot_index                           valid / ready
// o_rsp     out  status, granted_slot, free_count          valid / ready
//
// acquire: accepted in the idle state, then one tree level per cycle through the single read
// port of the node count ram.
// release: accept, leaf check, then one ancestor per cycle going up.
// pool full and bad index answer at accept, a release of a free slot at the leaf check.
// after reset a clearing pass over every ram address loads the tree, ready low.
// one output register: a result that finds it occupied waits in the done state.

module tree_slot_allocator #(
    parameter int SLOTS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tsa_in_if.sink        i_req,
    tsa_out_if.source     o_rsp
);

    localparam int LEVELS      = $clog2(SLOTS);
    localparam int TREE_LEAVES = 1 << LEVELS;
    localparam int AW          = LEVELS;
    localparam int TW          = LEVELS + 1;
    localparam int CW          = $clog2(SLOTS + 1);
    localparam int LW          = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int IW          = tsa_pkg::IDX_W;
    localparam int SW          = tsa_pkg::SLOT_W;
    localparam int FW          = tsa_pkg::FREE_W;
    localparam int STW         = tsa_pkg::STATUS_W;
    localparam bit IDX_ALL_OK  = SLOTS >= (1 << IW);

    tsa_pkg::t_state r_state, n_state;

    logic [AW-1:0]  r_node, n_node;
    logic [LW-1:0]  r_lvl, n_lvl;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [CW-1:0]  r_total, n_total;
    logic [AW-1:0]  r_idx, n_idx;
    logic [STW-1:0] r_res_status, n_res_status;
    logic [SW-1:0]  r_res_slot, n_res_slot;
    logic [AW-1:0]  r_clr, n_clr;
    logic [TW-1:0]  r_size, n_size;
    logic [TW-1:0]  r_first, n_first;
    logic [TW-1:0]  r_lvl_end, n_lvl_end;
    logic           r_out_valid, n_out_valid;
    logic [STW-1:0] r_out_status, n_out_status;
    logic [SW-1:0]  r_out_slot, n_out_slot;
    logic [FW-1:0]  r_out_free, n_out_free;

    logic           in_acc;
    logic           can_load;
    logic           fin;
    logic [STW-1:0] f_status;
    logic [SW-1:0]  f_slot;
    logic           idx_oob;
    logic           last_lvl;
    logic           left_free;
    logic [AW-1:0]  child_a;
    logic [TW-1:0]  clr_next;
    logic [TW-1:0]  init_avail;
    logic [CW-1:0]  init_cnt;

    logic [AW-1:0]  rd_addr;
    logic           node_we;
    logic [AW-1:0]  node_waddr;
    logic [CW-1:0]  node_wdata;
    logic [CW-1:0]  node_rd;
    logic           leaf_we;
    logic [AW-1:0]  leaf_waddr;
    logic           leaf_wdata;
    logic           leaf_rd;

    tsa_ram #(.WIDTH(CW), .AW(AW)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_raddr (rd_addr),
        .o_rdata (node_rd)
    );

    tsa_ram #(.WIDTH(1), .AW(AW)) u_leaf_ram (
        .i_clk   (i_clk),
        .i_we    (leaf_we),
        .i_waddr (leaf_waddr),
        .i_wdata (leaf_wdata),
        .i_raddr (rd_addr),
        .o_rdata (leaf_rd)
    );

    assign i_req.ready = (r_state == tsa_pkg::S_IDLE);
    assign in_acc      = i_req.valid && (r_state == tsa_pkg::S_IDLE);
    assign can_load    = !r_out_valid || o_rsp.ready;

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.granted_slot = r_out_slot;
    assign o_rsp.free_count   = r_out_free;

    assign idx_oob   = !IDX_ALL_OK && (i_req.slot_index >= IW'(SLOTS));
    assign last_lvl  = (r_lvl == LW'(LEVELS - 1));
    // children at the bottom level are leaf bits, above that node counts
    assign left_free = last_lvl ? leaf_rd : (node_rd != '0);
    assign child_a   = AW'({r_node, !left_free});

    // clearing pass: node j gets min(subtree size, real slots left past its first leaf)
    assign clr_next   = TW'(r_clr) + TW'(1);
    assign init_avail = TW'(SLOTS) - r_first;
    assign init_cnt   = (TW'(SLOTS) > r_first) ?
                        CW'((init_avail < r_size) ? init_avail : r_size) : '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            tsa_pkg::S_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = tsa_pkg::S_IDLE;
                end
            end
            tsa_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_req.cmd == tsa_pkg::CMD_ACQUIRE) ?
                              tsa_pkg::S_ACQ : tsa_pkg::S_RLS_CHK;
                end
            end
            tsa_pkg::S_ACQ:     n_state = r_state;
            tsa_pkg::S_RLS_CHK: n_state = tsa_pkg::S_RLS_UP;
            tsa_pkg::S_RLS_UP:  n_state = r_state;
            tsa_pkg::S_DONE: begin
                if (can_load) begin
                    n_state = tsa_pkg::S_IDLE;
                end
            end
            default: n_state = tsa_pkg::S_CLEAR;
        endcase
        if (fin) begin
            n_state = can_load ? tsa_pkg::S_IDLE : tsa_pkg::S_DONE;
        end
    end

    always_comb begin
        n_node       = r_node;
        n_lvl        = r_lvl;
        n_cnt        = r_cnt;
        n_total      = r_total;
        n_idx        = r_idx;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_clr        = r_clr;
        n_size       = r_size;
        n_first      = r_first;
        n_lvl_end    = r_lvl_end;
        fin          = 1'b0;
        f_status     = tsa_pkg::STAT_OK;
        f_slot       = '0;
        rd_addr      = '0;
        node_we      = 1'b0;
        node_waddr   = r_node;
        node_wdata   = r_cnt - CW'(1);
        leaf_we      = 1'b0;
        leaf_waddr   = r_idx;
        leaf_wdata   = 1'b1;

        case (r_state)
            tsa_pkg::S_CLEAR: begin
                leaf_we    = 1'b1;
                leaf_waddr = r_clr;
                leaf_wdata = TW'(r_clr) < TW'(SLOTS);
                n_clr      = r_clr + AW'(1);
                if (r_clr != '0) begin
                    node_we    = 1'b1;
                    node_waddr = r_clr;
                    node_wdata = init_cnt;
                    if (clr_next == r_lvl_end) begin
                        n_size    = r_size >> 1;
                        n_first   = '0;
                        n_lvl_end = r_lvl_end << 1;
                    end else begin
                        n_first = r_first + r_size;
                    end
                end
            end
            tsa_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_req.cmd == tsa_pkg::CMD_ACQUIRE) begin
                        if (r_total == '0) begin
                            fin      = 1'b1;
                            f_status = tsa_pkg::STAT_FULL;
                        end else begin
                            // first read is the root's left child
                            rd_addr = AW'(2);
                            n_node  = AW'(1);
                            n_lvl   = '0;
                            n_cnt   = r_total;
                            n_total = r_total - CW'(1);
                        end
                    end else begin
                        if (idx_oob) begin
                            fin      = 1'b1;
                            f_status = tsa_pkg::STAT_RANGE;
                        end else begin
                            rd_addr = AW'(i_req.slot_index);
                            n_idx   = AW'(i_req.slot_index);
                        end
                    end
                end
            end
            tsa_pkg::S_ACQ: begin
                node_we    = 1'b1;
                node_waddr = r_node;
                node_wdata = r_cnt - CW'(1);
                if (last_lvl) begin
                    leaf_we    = 1'b1;
                    leaf_waddr = child_a;
                    leaf_wdata = 1'b0;
                    fin        = 1'b1;
                    f_slot     = SW'(child_a);
                end else begin
                    // right child holds all of the parent's count when the left is empty
                    n_node  = child_a;
                    n_cnt   = left_free ? node_rd : r_cnt;
                    n_lvl   = r_lvl + LW'(1);
                    rd_addr = AW'({child_a, 1'b0});
                end
            end
            tsa_pkg::S_RLS_CHK: begin
                if (leaf_rd) begin
                    fin      = 1'b1;
                    f_status = tsa_pkg::STAT_ALREADY_FREE;
                end else begin
                    leaf_we    = 1'b1;
                    leaf_waddr = r_idx;
                    leaf_wdata = 1'b1;
                    rd_addr    = AW'((TW'(TREE_LEAVES) + TW'(r_idx)) >> 1);
                    n_node     = AW'((TW'(TREE_LEAVES) + TW'(r_idx)) >> 1);
                    n_total    = r_total + CW'(1);
                end
            end
            tsa_pkg::S_RLS_UP: begin
                node_we    = 1'b1;
                node_waddr = r_node;
                node_wdata = node_rd + CW'(1);
                if (r_node == AW'(1)) begin
                    fin = 1'b1;
                end else begin
                    rd_addr = r_node >> 1;
                    n_node  = r_node >> 1;
                end
            end
            tsa_pkg::S_DONE: begin
                fin = 1'b0;
            end
            default: begin
                fin = 1'b0;
            end
        endcase

        if (fin && !can_load) begin
            n_res_status = f_status;
            n_res_slot   = f_slot;
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_free   = r_out_free;
        if (fin && can_load) begin
            n_out_valid  = 1'b1;
            n_out_status = f_status;
            n_out_slot   = f_slot;
            n_out_free   = FW'(n_total);
        end else if ((r_state == tsa_pkg::S_DONE) && can_load) begin
            n_out_valid  = 1'b1;
            n_out_status = r_res_status;
            n_out_slot   = r_res_slot;
            n_out_free   = FW'(r_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsa_pkg::S_CLEAR;
            r_clr       <= '0;
            r_size      <= TW'(TREE_LEAVES);
            r_first     <= '0;
            r_lvl_end   <= TW'(2);
            r_total     <= CW'(SLOTS);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_size      <= n_size;
            r_first     <= n_first;
            r_lvl_end   <= n_lvl_end;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node       <= n_node;
        r_lvl        <= n_lvl;
        r_cnt        <= n_cnt;
        r_idx        <= n_idx;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_free   <= n_out_free;
    end

endmodule

`default_nettype wire

### rtl/tsa_checker.sv
`default_nettype none
`include "tree_slot_allocator_assert.svh"

module tsa_checker #(
    parameter int SLOTS = 64
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [tsa_pkg::STATUS_W-1:0]  i_status,
    input logic [tsa_pkg::SLOT_W-1:0]    i_granted_slot,
    input logic [tsa_pkg::FREE_W-1:0]    i_free_count
);

    // a result stays up until it is taken
    `TSA_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)

    `TSA_ASSERT_IMP(a_slot_only_on_ok,
                    i_out_valid && (i_status != tsa_pkg::STAT_OK), i_granted_slot == '0)

    `TSA_ASSERT_IMP(a_full_means_empty,
                    i_out_valid && (i_status == tsa_pkg::STAT_FULL), i_free_count == '0)

    `TSA_ASSERT_IMP(a_free_bounded, i_out_valid, i_free_count <= SLOTS)

endmodule

bind tree_slot_allocator tsa_checker #(.SLOTS(SLOTS)) u_tsa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_granted_slot (o_rsp.granted_slot),
    .i_free_count   (o_rsp.free_count)
);

`default_nettype wire

### tb/tb_tree_slot_allocator.sv
`timescale 1ns / 1ps

module tb_tree_slot_allocator;

    localparam int IDX_W    = tsa_pkg::IDX_W;
    localparam int STATUS_W = tsa_pkg::STATUS_W;
    localparam int SLOT_W   = tsa_pkg::SLOT_W;
    localparam int FREE_W   = tsa_pkg::FREE_W;

    localparam int POOL        = 64;
    localparam int LEAVES      = 64;
    localparam int RAND_ITEMS  = 600;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 30;
    localparam int HOLD_AT     = 450;
    localparam int HOLD_CYCLES = 300;

    localparam logic [1:0] MODE_RX_SLOW = 2'd0;
    localparam logic [1:0] MODE_TX_SLOW = 2'd1;
    localparam logic [1:0] MODE_NO_IDLE = 2'd2;

    typedef enum int {
        BURST_FILL,
        BURST_DRAIN,
        BURST_MIXED
    } t_burst;

    typedef struct {
        logic             cmd;
        logic [IDX_W-1:0] idx;
        bit               drain_first;
        logic [1:0]       mode;
    } t_req_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [FREE_W-1:0]   free;
    } t_rsp;

    logic i_clk;
    logic i_rst_n;

    tsa_in_if  req_if ();
    tsa_out_if rsp_if ();

    tree_slot_allocator #(.SLOTS(POOL)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow copy of the allocator tree
    logic              leaf_avail [0:POOL-1];
    logic [FREE_W-1:0] node_cnt   [1:LEAVES-1];

    t_req_item req_backlog_q[$];
    t_rsp      outstanding_rsp_q[$];
    t_req_item next_item;
    logic [1:0] idle_mode;
    int        fail_count;
    int        n_results;
    int        hold_left;
    int        cycle_count;

    function automatic logic [FREE_W-1:0] free_below(input int c);
        if (c >= LEAVES)
            return {{(FREE_W-1){1'b0}}, leaf_avail[c-LEAVES]};
        return node_cnt[c];
    endfunction

    function automatic t_rsp pool_apply(input logic cmd, input logic [IDX_W-1:0] idx);
        t_rsp r;
        int   n;
        r.status = tsa_pkg::STAT_OK;
        r.slot   = '0;
        if (cmd == tsa_pkg::CMD_ACQUIRE) begin
            if (node_cnt[1] == 0) begin
                r.status = tsa_pkg::STAT_FULL;
            end else begin
                n = 1;
                // walk down, prefer the left child whenever it has room
                while (n < LEAVES) begin
                    if (node_cnt[n] != 0)
                        node_cnt[n] = node_cnt[n] - 1'b1;
                    n = (free_below(2 * n) != 0) ? 2 * n : 2 * n + 1;
                end
                r.slot = SLOT_W'(n - LEAVES);
                leaf_avail[n - LEAVES] = 1'b0;
            end
        end else begin
            if (int'(idx) >= POOL) begin
                r.status = tsa_pkg::STAT_RANGE;
            end else if (leaf_avail[idx]) begin
                r.status = tsa_pkg::STAT_ALREADY_FREE;
            end else begin
                leaf_avail[idx] = 1'b1;
                n = (LEAVES + int'(idx)) >> 1;
                while (n >= 1) begin
                    node_cnt[n] = node_cnt[n] + 1'b1;
                    n = n >> 1;
                end
            end
        end
        r.free = node_cnt[1];
        return r;
    endfunction

    function automatic int tx_idle_pct(input logic [1:0] mode);
        case (mode)
            MODE_RX_SLOW: return 8;
            MODE_TX_SLOW: return 79;
            default:      return 0;
        endcase
    endfunction

    function automatic int rx_idle_pct(input logic [1:0] mode);
        case (mode)
            MODE_RX_SLOW: return 79;
            MODE_TX_SLOW: return 8;
            default:      return 0;
        endcase
    endfunction

    task automatic add_req(input logic cmd, input logic [IDX_W-1:0] idx,
                           input bit drain_first, input logic [1:0] mode);
        t_req_item it;
        it.cmd         = cmd;
        it.idx         = idx;
        it.drain_first = drain_first;
        it.mode        = mode;
        req_backlog_q.insert(req_backlog_q.size(), it);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // driver: offers backlog items, predicts each accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready)
                outstanding_rsp_q.insert(outstanding_rsp_q.size(),
                                         pool_apply(req_if.cmd, req_if.slot_index));
            if (!req_if.valid || req_if.ready) begin
                if (req_backlog_q.size() != 0 &&
                    !(req_backlog_q[0].drain_first && outstanding_rsp_q.size() != 0) &&
                    $urandom_range(99) >= tx_idle_pct(req_backlog_q[0].mode)) begin
                    next_item = req_backlog_q.pop_front();
                    req_if.valid      <= 1'b1;
                    req_if.cmd        <= next_item.cmd;
                    req_if.slot_index <= next_item.idx;
                    idle_mode         <= next_item.mode;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // one long back-pressure stretch so the block fills and stalls its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (rsp_if.valid && rsp_if.ready && n_results == HOLD_AT - 1) begin
            hold_left <= HOLD_CYCLES;
        end
    end

    // monitor: checks each response against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (outstanding_rsp_q.size() == 0) begin
                    $display("%0t: unexpected response status=%0d slot=%0d free=%0d", $time,
                             rsp_if.status, rsp_if.granted_slot, rsp_if.free_count);
                    fail_count++;
                end else begin
                    if (rsp_if.status !== outstanding_rsp_q[0].status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 outstanding_rsp_q[0].status, rsp_if.status);
                        fail_count++;
                    end
                    if (rsp_if.granted_slot !== outstanding_rsp_q[0].slot) begin
                        $display("%0t: granted_slot expected %0d actual %0d", $time,
                                 outstanding_rsp_q[0].slot, rsp_if.granted_slot);
                        fail_count++;
                    end
                    if (rsp_if.free_count !== outstanding_rsp_q[0].free) begin
                        $display("%0t: free_count expected %0d actual %0d", $time,
                                 outstanding_rsp_q[0].free, rsp_if.free_count);
                        fail_count++;
                    end
                    void'(outstanding_rsp_q.pop_front());
                end
                n_results <= n_results + 1;
            end
            if (hold_left != 0) begin
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct(idle_mode));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int     n;
        int     k;
        int     len;
        int     acq_pct;
        t_burst burst;
        logic   cmd;
        logic [IDX_W-1:0] idx;
        logic [1:0] mode;

        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.cmd        = tsa_pkg::CMD_ACQUIRE;
        req_if.slot_index = '0;
        rsp_if.ready      = 1'b0;
        idle_mode         = MODE_RX_SLOW;
        fail_count        = 0;
        n_results         = 0;
        hold_left         = 0;
        cycle_count       = 0;

        for (n = 0; n < POOL; n++)
            leaf_avail[n] = 1'b1;
        for (n = LEAVES - 1; n >= 1; n--)
            node_cnt[n] = free_below(2 * n) + free_below(2 * n + 1);

        // directed: bad indexes, double release, ignored index on acquire
        add_req(tsa_pkg::CMD_RELEASE, 8'd0,   1'b0, MODE_RX_SLOW);
        add_req(tsa_pkg::CMD_RELEASE, 8'd63,  1'b0, MODE_RX_SLOW);
        add_req(tsa_pkg::CMD_RELEASE, 8'd64,  1'b0, MODE_RX_SLOW);
        add_req(tsa_pkg::CMD_RELEASE, 8'd255, 1'b0, MODE_RX_SLOW);
        add_req(tsa_pkg::CMD_RELEASE, 8'd128, 1'b0, MODE_RX_SLOW);
        add_req(tsa_pkg::CMD_ACQUIRE, 8'd0,   1'b0, MODE_RX_SLOW);
        add_req(tsa_pkg::CMD_ACQUIRE, 8'd255, 1'b0, MODE_RX_SLOW);
        add_req(tsa_pkg::CMD_ACQUIRE, 8'd170, 1'b0, MODE_RX_SLOW);
        add_req(tsa_pkg::CMD_ACQUIRE, 8'd85,  1'b0, MODE_RX_SLOW);
        add_req(tsa_pkg::CMD_RELEASE, 8'd1,   1'b0, MODE_RX_SLOW);
        add_req(tsa_pkg::CMD_RELEASE, 8'd1,   1'b0, MODE_RX_SLOW);
        add_req(tsa_pkg::CMD_ACQUIRE, 8'd0,   1'b0, MODE_RX_SLOW);
        add_req(tsa_pkg::CMD_RELEASE, 8'd0,   1'b0, MODE_RX_SLOW);
        add_req(tsa_pkg::CMD_RELEASE, 8'd3,   1'b0, MODE_RX_SLOW);
        add_req(tsa_pkg::CMD_RELEASE, 8'd2,   1'b0, MODE_RX_SLOW);
        add_req(tsa_pkg::CMD_RELEASE, 8'd2,   1'b0, MODE_RX_SLOW);
        add_req(tsa_pkg::CMD_RELEASE, 8'd1,   1'b0, MODE_RX_SLOW);
        add_req(tsa_pkg::CMD_RELEASE, 8'd127, 1'b0, MODE_RX_SLOW);
        add_req(tsa_pkg::CMD_ACQUIRE, 8'd64,  1'b0, MODE_RX_SLOW);
        add_req(tsa_pkg::CMD_RELEASE, 8'd0,   1'b0, MODE_RX_SLOW);

        // random: fill, drain and mixed bursts so the pool reaches full and empty often
        n = 0;
        while (n < RAND_ITEMS) begin
            burst = t_burst'($urandom_range(2));
            len   = $urandom_range(110, 20);
            case (burst)
                BURST_FILL:  acq_pct = 95;
                BURST_DRAIN: acq_pct = 8;
                default:     acq_pct = 50;
            endcase
            for (k = 0; k < len && n < RAND_ITEMS; k++) begin
                mode = (n < RAND_ITEMS / 3) ? MODE_RX_SLOW :
                       (n < 2 * RAND_ITEMS / 3) ? MODE_TX_SLOW : MODE_NO_IDLE;
                if ($urandom_range(99) < acq_pct) begin
                    cmd = tsa_pkg::CMD_ACQUIRE;
                    idx = IDX_W'($urandom_range(255));
                end else begin
                    cmd = tsa_pkg::CMD_RELEASE;
                    idx = ($urandom_range(9) == 0) ? IDX_W'($urandom_range(255, 64))
                                                   : IDX_W'($urandom_range(POOL - 1));
                end
                // pause until the block is drained at phase changes and once mid-run
                add_req(cmd, idx, (n == 0 || n == RAND_ITEMS / 3 || n == RAND_ITEMS / 2 ||
                                   n == 2 * RAND_ITEMS / 3), mode);
                n++;
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_backlog_q.size() != 0 || req_if.valid || outstanding_rsp_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/tsa_pkg.sv
rtl/tsa_in_if.sv
rtl/tsa_out_if.sv
rtl/tsa_ram.sv
rtl/tree_slot_allocator.sv
rtl/tsa_checker.sv
tb/tb_tree_slot_allocator.sv
